// ----- hdl/iaf_pkg.sv -----
// Shared types, constants and helpers of the integer to ASCII formatter.
// No dependencies; every other file takes names from here by scoped reference.
`default_nettype none
package iaf_pkg;

  localparam int unsigned MAX_DIGITS = 20;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DIGIT_W    = MAX_DIGITS * 4;
  localparam int unsigned PTR_W      = $clog2(MAX_DIGITS);
  localparam int unsigned STEP_W     = $clog2(VALUE_W);
  localparam int unsigned CHAR_W     = 7;

  // queue between front and back; depth must be a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEXL = 2'd2;
  localparam logic [1:0] MODE_HEXU = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_A_UPPER = 7'h41;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               hex;
    logic               upper;
  } item_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] dx;
    dx = {3'b000, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + dx;
    end else if (upper) begin
      return CHAR_A_UPPER + dx - 7'd10;
    end else begin
      return CHAR_A_LOWER + dx - 7'd10;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/iaf_front.sv -----
// Front end: accepts an item, applies the sign rule and registers the
// classified item for the queue. Depends on iaf_pkg.
`default_nettype none
module iaf_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [iaf_pkg::VALUE_W-1:0]  value_i,
  input  wire logic [1:0]                   mode_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output iaf_pkg::item_t                    out_item_o
);

  logic           valid_q, valid_d;
  iaf_pkg::item_t item_q, item_d;
  logic           neg;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    neg           = (mode_i == iaf_pkg::MODE_SDEC) && value_i[iaf_pkg::VALUE_W-1];
    item_d.neg    = neg;
    // most negative value wraps to itself, which is its correct magnitude
    item_d.mag    = neg ? (~value_i + 1'b1) : value_i;
    item_d.hex    = (mode_i == iaf_pkg::MODE_HEXL) || (mode_i == iaf_pkg::MODE_HEXU);
    item_d.upper  = (mode_i == iaf_pkg::MODE_HEXU);
    valid_d       = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iaf_queue.sv -----
// Short queue of classified items between the front end and the converter.
// Depends on iaf_pkg.
`default_nettype none
module iaf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire iaf_pkg::item_t push_item_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output iaf_pkg::item_t      pop_item_o
);

  iaf_pkg::item_t              mem_q [iaf_pkg::QUEUE_DEPTH];
  logic [iaf_pkg::QPTR_W-1:0]  wptr_q, wptr_d;
  logic [iaf_pkg::QPTR_W-1:0]  rptr_q, rptr_d;
  logic [iaf_pkg::QPTR_W:0]    count_q, count_d;
  logic                        push, pop;

  // full exactly when the count reaches the power-of-two depth
  assign push_ready_o = (count_q[iaf_pkg::QPTR_W] == 1'b0);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iaf_back.sv -----
// Back end: bit-serial binary to BCD conversion (shift and add-3), leading
// zero skip and character emission. Depends on iaf_pkg.
`default_nettype none
module iaf_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire iaf_pkg::item_t              in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [iaf_pkg::CHAR_W-1:0]       out_char_o,
  output logic                             out_last_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SKIP  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [iaf_pkg::VALUE_W-1:0]  bin_q, bin_d;
  logic [iaf_pkg::DIGIT_W-1:0]  digits_q, digits_d;
  logic [iaf_pkg::DIGIT_W-1:0]  adj;
  logic [iaf_pkg::STEP_W-1:0]   step_q, step_d;
  logic [iaf_pkg::PTR_W-1:0]    ptr_q, ptr_d;
  logic                         neg_q, neg_d;
  logic                         upper_q, upper_d;
  logic                         ovf_q, ovf_d;
  logic [3:0]                   cur_digit;
  logic [3:0]                   nib;

  assign cur_digit  = digits_q[{ptr_q, 2'b00} +: 4];
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    out_valid_o = 1'b0;
    out_char_o  = iaf_pkg::CHAR_MINUS;
    out_last_o  = 1'b0;
    unique case (state_q)
      S_SIGN: begin
        out_valid_o = 1'b1;
      end
      S_DIGIT: begin
        out_valid_o = 1'b1;
        out_char_o  = iaf_pkg::digit_char(cur_digit, upper_q);
        out_last_o  = (ptr_q == '0);
      end
      default: begin
      end
    endcase
  end

  // add 3 to every BCD digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < int'(iaf_pkg::MAX_DIGITS); i++) begin
      nib = digits_q[i*4 +: 4];
      adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_comb begin
    state_d  = state_q;
    bin_d    = bin_q;
    digits_d = digits_q;
    step_d   = step_q;
    ptr_d    = ptr_q;
    neg_d    = neg_q;
    upper_d  = upper_q;
    ovf_d    = ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          neg_d   = in_item_i.neg;
          upper_d = in_item_i.upper;
          ovf_d   = 1'b0;
          step_d  = '0;
          ptr_d   = iaf_pkg::PTR_W'(iaf_pkg::MAX_DIGITS - 1);
          bin_d   = in_item_i.mag;
          if (in_item_i.hex) begin
            digits_d = iaf_pkg::DIGIT_W'(in_item_i.mag);
            state_d  = S_SKIP;
          end else begin
            digits_d = '0;
            state_d  = S_CONV;
          end
        end
      end
      S_CONV: begin
        digits_d = {adj[iaf_pkg::DIGIT_W-2:0], bin_q[iaf_pkg::VALUE_W-1]};
        // a carry out of the top digit means high digits were dropped
        ovf_d    = ovf_q | adj[iaf_pkg::DIGIT_W-1];
        bin_d    = {bin_q[iaf_pkg::VALUE_W-2:0], 1'b0};
        step_d   = step_q + 1'b1;
        if (step_q == iaf_pkg::STEP_W'(iaf_pkg::VALUE_W - 1)) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((ptr_q != '0) && (cur_digit == 4'd0) && !ovf_q) begin
          ptr_d = ptr_q - 1'b1;
        end else begin
          state_d = neg_q ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_ready_i) begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_ready_i) begin
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      ptr_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ptr_q   <= ptr_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    digits_q <= digits_d;
    upper_q  <= upper_d;
  end

endmodule
`default_nettype wire

// ----- hdl/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter: front end, item queue and
// converter/emitter. Depends on iaf_pkg, iaf_front, iaf_queue and iaf_back.
//
// Formats a 64-bit value as ASCII text, one character per output item, most
// significant digit first, with tlast on the final character. tuser selects
// unsigned decimal, signed decimal, lowercase hex or uppercase hex. Signed
// negative values get a leading minus sign; zero gives the single character
// 0; leading zeros are suppressed. The converter handles one number at a
// time: a decimal number is loaded, converted by shift-and-add-3 over all
// 64 value bits and stripped of leading zero digits, then its characters
// are emitted, each held until accepted; a hex number skips the conversion.
// The front end and a two-entry queue keep accepting numbers while the
// converter is busy, until both are full.
`default_nettype none
module integer_to_ascii_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] value
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic             m_axis_tlast_o    // last
);

  iaf_pkg::item_t             front_item, queue_item;
  logic                       front_valid, queue_ready;
  logic                       queue_valid, back_ready;
  logic [iaf_pkg::CHAR_W-1:0] out_char;

  iaf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .value_i     (s_axis_tdata_i),
    .mode_i      (s_axis_tuser_i),
    .out_valid_o (front_valid),
    .out_ready_i (queue_ready),
    .out_item_o  (front_item)
  );

  iaf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (queue_item)
  );

  iaf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (queue_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (queue_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

endmodule
`default_nettype wire
